FILE: hdl/ebh_pkg.sv
package ebh_pkg;

    // Field widths fixed by the request and result formats.
    localparam int SLOT_W       = 5;
    localparam int VALUE_W      = 32;
    localparam int REQ_W        = 2;
    localparam int STATUS_W     = 2;
    localparam int OUT_COUNT_W  = 32;
    localparam int EDGE_COUNT_W = 5;

    // Configuration port format.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    // Defaults for the top-level parameters.
    localparam int MAX_EDGES_DEF   = 16;
    localparam int COUNT_WIDTH_DEF = 32;

    // Request types.
    typedef enum logic [REQ_W-1:0] {
        REQ_WRITE_EDGE = 2'd0,
        REQ_INSERT     = 2'd1,
        REQ_READ_BIN   = 2'd2,
        REQ_NONE       = 2'd3
    } t_req;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_READY = 2'd1,
        ST_NOT_ASC   = 2'd2,
        ST_BAD_SLOT  = 2'd3
    } t_status;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_EDGE_COUNT  = 2'd0,
        CFG_CLOSED_ENDS = 2'd1,
        CFG_SPARE_2     = 2'd2,
        CFG_SPARE_3     = 2'd3
    } t_cfg_idx;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_EDGE_CHECK,
        S_TOP_CHECK,
        S_WALK,
        S_COUNT,
        S_RESULT
    } t_state;

    // Outcome of the shared signed comparator.
    typedef struct packed {
        logic lt;
        logic gt;
    } t_cmp_res;

endpackage

FILE: hdl/ebh_ram.sv
module ebh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: hdl/ebh_cmp.sv
module ebh_cmp (
    input  logic signed [ebh_pkg::VALUE_W-1:0] i_value,
    input  logic signed [ebh_pkg::VALUE_W-1:0] i_edge,
    output ebh_pkg::t_cmp_res                  o_res
);

    // Signed two's-complement compare of the working value against one edge.
    always_comb begin
        o_res.lt = (i_value < i_edge);
        o_res.gt = (i_value > i_edge);
    end

endmodule

FILE: hdl/edge_binned_histogram_top.sv
// Histogram with programmable ascending bin edges over signed Q16.16 values.
// Edges go in with edge-write requests in slot order; a write to slot 0
// clears every count and restarts the load, and a value not above the edge
// below it is refused. Once edge_count edges are loaded (and at least two in
// closed mode), insert requests place a sample in its bin and bump that bin's
// saturating count (in closed mode a sample outside the end edges is not
// counted); read requests return any bin's count at any time. One request is
// taken at a time and the input is not ready until its result has been loaded
// into the output register. One signed comparator checks the edges one per
// cycle, walking down from the top edge through the edge memory's registered
// read port, followed by a read-modify-write of the count memory. Counts are
// zero after reset with no clearing pass; per-bin valid bits stand in for the
// clear.
module edge_binned_histogram_top #(
    parameter int MAX_EDGES   = ebh_pkg::MAX_EDGES_DEF,
    parameter int COUNT_WIDTH = ebh_pkg::COUNT_WIDTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Request channel.
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic [ebh_pkg::REQ_W-1:0]            i_req_type,
    input  logic [ebh_pkg::SLOT_W-1:0]           i_slot,
    input  logic signed [ebh_pkg::VALUE_W-1:0]   i_sample_value,
    // Result channel.
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic [ebh_pkg::STATUS_W-1:0]         o_status,
    output logic                                 o_counted,
    output logic [ebh_pkg::SLOT_W-1:0]           o_bin_number,
    output logic [ebh_pkg::OUT_COUNT_W-1:0]      o_bin_count,
    // Configuration write channel.
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [ebh_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [ebh_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    localparam int IDX_W   = $clog2(MAX_EDGES);
    localparam int BIN_W   = $clog2(MAX_EDGES + 1);
    localparam int NBINS   = MAX_EDGES + 1;
    localparam int CMP_W   = ((BIN_W > ebh_pkg::SLOT_W) ? BIN_W : ebh_pkg::SLOT_W) + 1;
    localparam int VALUE_W = ebh_pkg::VALUE_W;

    // Control and working registers.
    ebh_pkg::t_state              r_state, n_state;
    logic [ebh_pkg::REQ_W-1:0]    r_req, n_req;
    logic [ebh_pkg::SLOT_W-1:0]   r_slot, n_slot;
    logic signed [VALUE_W-1:0]    r_value, n_value;
    logic [BIN_W-1:0]             r_idx, n_idx;
    logic [ebh_pkg::STATUS_W-1:0] r_status, n_status;
    logic                         r_counted, n_counted;
    logic [BIN_W-1:0]             r_bin, n_bin;
    logic [COUNT_WIDTH-1:0]       r_count, n_count;
    logic [BIN_W-1:0]             r_loaded, n_loaded;
    logic [NBINS-1:0]             r_cnt_vld, n_cnt_vld;
    logic [ebh_pkg::EDGE_COUNT_W-1:0] r_edge_count;
    logic                         r_closed;

    // Output register.
    logic                         r_out_valid, n_out_valid;
    logic [ebh_pkg::STATUS_W-1:0] r_out_status;
    logic                         r_out_counted;
    logic [ebh_pkg::SLOT_W-1:0]   r_out_bin;
    logic [ebh_pkg::OUT_COUNT_W-1:0] r_out_count;

    // Memory ports.
    logic                         edge_wr_en, edge_rd_en;
    logic [IDX_W-1:0]             edge_wr_addr, edge_rd_addr;
    logic [VALUE_W-1:0]           edge_wr_data;
    logic [VALUE_W-1:0]           edge_rd_data;
    logic                         cnt_wr_en, cnt_rd_en;
    logic [BIN_W-1:0]             cnt_wr_addr, cnt_rd_addr;
    logic [COUNT_WIDTH-1:0]       cnt_wr_data, cnt_rd_data;

    // Helper values.
    ebh_pkg::t_cmp_res            cmp;
    logic                         accept;
    logic                         load_out;
    logic                         table_ready;
    logic [CMP_W-1:0]             slot_x, ec_x, loaded_x, r_slot_x, bin_x;
    logic [COUNT_WIDTH-1:0]       cur_count, inc_count;
    logic [63:0]                  count_x;

    // Edge storage and count storage.
    ebh_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (MAX_EDGES)
    ) u_edge_ram (
        .i_clk     (i_clk),
        .i_wr_en   (edge_wr_en),
        .i_wr_addr (edge_wr_addr),
        .i_wr_data (edge_wr_data),
        .i_rd_en   (edge_rd_en),
        .i_rd_addr (edge_rd_addr),
        .o_rd_data (edge_rd_data)
    );

    ebh_ram #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (NBINS)
    ) u_count_ram (
        .i_clk     (i_clk),
        .i_wr_en   (cnt_wr_en),
        .i_wr_addr (cnt_wr_addr),
        .i_wr_data (cnt_wr_data),
        .i_rd_en   (cnt_rd_en),
        .i_rd_addr (cnt_rd_addr),
        .o_rd_data (cnt_rd_data)
    );

    // Shared comparator: working value against the edge just read.
    ebh_cmp u_cmp (
        .i_value (r_value),
        .i_edge  (edge_rd_data),
        .o_res   (cmp)
    );

    // Widened copies for mixed-width compares.
    assign slot_x   = CMP_W'(i_slot);
    assign r_slot_x = CMP_W'(r_slot);
    assign ec_x     = CMP_W'(r_edge_count);
    assign loaded_x = CMP_W'(r_loaded);
    assign bin_x    = CMP_W'(r_bin);

    // The table can take samples once enough ascending edges are held.
    assign table_ready = (ec_x <= CMP_W'(MAX_EDGES)) && (loaded_x >= ec_x)
                         && !(r_closed && (ec_x < CMP_W'(2)));

    // Count seen by the read-modify-write; a bin without its valid bit is zero.
    assign cur_count = r_cnt_vld[r_bin] ? cnt_rd_data : '0;
    assign inc_count = (&cur_count) ? cur_count : cur_count + COUNT_WIDTH'(1);

    assign o_ready     = (r_state == ebh_pkg::S_IDLE);
    assign accept      = i_valid && o_ready;
    assign load_out    = (r_state == ebh_pkg::S_RESULT) && (!r_out_valid || i_ready);
    assign o_cfg_ready = 1'b1;

    // Sequencer: next state, working registers and memory control.
    always_comb begin
        n_state     = r_state;
        n_req       = r_req;
        n_slot      = r_slot;
        n_value     = r_value;
        n_idx       = r_idx;
        n_status    = r_status;
        n_counted   = r_counted;
        n_bin       = r_bin;
        n_count     = r_count;
        n_loaded    = r_loaded;
        n_cnt_vld   = r_cnt_vld;
        edge_wr_en   = 1'b0;
        edge_wr_addr = '0;
        edge_wr_data = r_value;
        edge_rd_en   = 1'b0;
        edge_rd_addr = '0;
        cnt_wr_en    = 1'b0;
        cnt_wr_addr  = r_bin;
        cnt_wr_data  = inc_count;
        cnt_rd_en    = 1'b0;
        cnt_rd_addr  = '0;

        case (r_state)
            ebh_pkg::S_IDLE: begin
                if (accept) begin
                    n_req     = i_req_type;
                    n_slot    = i_slot;
                    n_value   = i_sample_value;
                    n_status  = ebh_pkg::ST_OK;
                    n_counted = 1'b0;
                    n_bin     = '0;
                    n_count   = '0;
                    n_state   = ebh_pkg::S_RESULT;
                    case (i_req_type)
                        ebh_pkg::REQ_WRITE_EDGE: begin
                            if (slot_x >= CMP_W'(MAX_EDGES) ||
                                (slot_x != '0 && slot_x != loaded_x)) begin
                                n_status = ebh_pkg::ST_BAD_SLOT;
                            end else if (slot_x == '0) begin
                                // Slot 0 restarts the load and clears all counts.
                                edge_wr_en   = 1'b1;
                                edge_wr_addr = '0;
                                edge_wr_data = i_sample_value;
                                n_loaded     = BIN_W'(1);
                                n_cnt_vld    = '0;
                            end else begin
                                edge_rd_en   = 1'b1;
                                edge_rd_addr = IDX_W'(slot_x - CMP_W'(1));
                                n_state      = ebh_pkg::S_EDGE_CHECK;
                            end
                        end
                        ebh_pkg::REQ_INSERT: begin
                            if (!table_ready) begin
                                n_status = ebh_pkg::ST_NOT_READY;
                            end else if (r_closed) begin
                                // Check the top edge first.
                                edge_rd_en   = 1'b1;
                                edge_rd_addr = IDX_W'(ec_x - CMP_W'(1));
                                n_state      = ebh_pkg::S_TOP_CHECK;
                            end else if (ec_x == '0) begin
                                // Open mode with no edges: a single bin.
                                cnt_rd_en   = 1'b1;
                                cnt_rd_addr = '0;
                                n_bin       = '0;
                                n_state     = ebh_pkg::S_COUNT;
                            end else begin
                                edge_rd_en   = 1'b1;
                                edge_rd_addr = IDX_W'(ec_x - CMP_W'(1));
                                n_idx        = BIN_W'(ec_x);
                                n_state      = ebh_pkg::S_WALK;
                            end
                        end
                        ebh_pkg::REQ_READ_BIN: begin
                            if (slot_x > CMP_W'(MAX_EDGES)) begin
                                n_status = ebh_pkg::ST_BAD_SLOT;
                            end else begin
                                cnt_rd_en   = 1'b1;
                                cnt_rd_addr = BIN_W'(slot_x);
                                n_bin       = BIN_W'(slot_x);
                                n_state     = ebh_pkg::S_COUNT;
                            end
                        end
                        default: begin
                            n_state = ebh_pkg::S_RESULT;
                        end
                    endcase
                end
            end

            ebh_pkg::S_EDGE_CHECK: begin
                // New edge must lie strictly above the one below it.
                if (!cmp.gt) begin
                    n_status = ebh_pkg::ST_NOT_ASC;
                end else begin
                    edge_wr_en   = 1'b1;
                    edge_wr_addr = IDX_W'(r_slot_x);
                    n_loaded     = BIN_W'(r_slot_x + CMP_W'(1));
                end
                n_state = ebh_pkg::S_RESULT;
            end

            ebh_pkg::S_TOP_CHECK: begin
                // Above the top edge misses in closed mode; else walk down.
                if (cmp.gt) begin
                    n_state = ebh_pkg::S_RESULT;
                end else begin
                    edge_rd_en   = 1'b1;
                    edge_rd_addr = IDX_W'(ec_x - CMP_W'(2));
                    n_idx        = BIN_W'(ec_x - CMP_W'(1));
                    n_state      = ebh_pkg::S_WALK;
                end
            end

            ebh_pkg::S_WALK: begin
                // Edge r_idx-1 is on the read port; the next lower is fetched ahead.
                edge_rd_en   = 1'b1;
                edge_rd_addr = IDX_W'(r_idx - BIN_W'(2));
                if (cmp.lt) begin
                    if (r_idx == BIN_W'(1)) begin
                        // Below the bottom edge.
                        if (r_closed) begin
                            n_state = ebh_pkg::S_RESULT;
                        end else begin
                            cnt_rd_en   = 1'b1;
                            cnt_rd_addr = '0;
                            n_bin       = '0;
                            n_state     = ebh_pkg::S_COUNT;
                        end
                    end else begin
                        n_idx = r_idx - BIN_W'(1);
                    end
                end else begin
                    cnt_rd_en = 1'b1;
                    if (r_closed) begin
                        cnt_rd_addr = r_idx - BIN_W'(1);
                        n_bin       = r_idx - BIN_W'(1);
                    end else begin
                        cnt_rd_addr = r_idx;
                        n_bin       = r_idx;
                    end
                    n_state = ebh_pkg::S_COUNT;
                end
            end

            ebh_pkg::S_COUNT: begin
                // Count arrives; inserts bump it, reads just report it.
                if (r_req == ebh_pkg::REQ_INSERT) begin
                    cnt_wr_en          = 1'b1;
                    n_cnt_vld[r_bin]   = 1'b1;
                    n_counted          = 1'b1;
                    n_count            = inc_count;
                end else begin
                    n_count = cur_count;
                end
                n_state = ebh_pkg::S_RESULT;
            end

            ebh_pkg::S_RESULT: begin
                if (load_out) begin
                    n_state = ebh_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = ebh_pkg::S_IDLE;
            end
        endcase
    end

    // Output register valid flag.
    always_comb begin
        if (load_out) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ebh_pkg::S_IDLE;
            r_loaded     <= '0;
            r_cnt_vld    <= '0;
            r_out_valid  <= 1'b0;
            r_edge_count <= '0;
            r_closed     <= 1'b1;
        end else begin
            r_state     <= n_state;
            r_loaded    <= n_loaded;
            r_cnt_vld   <= n_cnt_vld;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    ebh_pkg::CFG_EDGE_COUNT: begin
                        r_edge_count <= i_cfg_data[ebh_pkg::EDGE_COUNT_W-1:0];
                    end
                    ebh_pkg::CFG_CLOSED_ENDS: begin
                        r_closed <= i_cfg_data[0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // Working payload registers.
    always_ff @(posedge i_clk) begin
        r_req     <= n_req;
        r_slot    <= n_slot;
        r_value   <= n_value;
        r_idx     <= n_idx;
        r_status  <= n_status;
        r_counted <= n_counted;
        r_bin     <= n_bin;
        r_count   <= n_count;
    end

    // Result payload register.
    assign count_x = 64'(r_count);

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_status  <= r_status;
            r_out_counted <= r_counted;
            r_out_bin     <= bin_x[ebh_pkg::SLOT_W-1:0];
            r_out_count   <= count_x[ebh_pkg::OUT_COUNT_W-1:0];
        end
    end

    assign o_valid      = r_out_valid;
    assign o_status     = r_out_status;
    assign o_counted    = r_out_counted;
    assign o_bin_number = r_out_bin;
    assign o_bin_count  = r_out_count;

endmodule
